>>> sv/pttt_pkg.sv
`default_nettype none

package pttt_pkg;

  // Field widths of the transfer payloads.
  localparam int OpW      = 2;
  localparam int TaskIdW  = 8;
  localparam int DelayW   = 16;
  localparam int StatusW  = 3;
  localparam int UsedW    = 5;

  // Dispatch emits at most this many ready ids in one pass.
  localparam int MaxResults = 16;
  localparam int ResIdxW    = $clog2(MaxResults);
  localparam int ResCntW    = $clog2(MaxResults + 1);

  typedef enum logic [OpW-1:0] {
    OpTick     = 2'd0,
    OpSet      = 2'd1,
    OpDelete   = 2'd2,
    OpDispatch = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StatTick    = 3'd0,
    StatUpdated = 3'd1,
    StatAdded   = 3'd2,
    StatIgnored = 3'd3,
    StatDeleted = 3'd4,
    StatReady   = 3'd5,
    StatNone    = 3'd6
  } status_e;

  // One timer entry as it is held in the table memory.
  typedef struct packed {
    logic [TaskIdW-1:0] id;
    logic [DelayW-1:0]  delay;
    logic [DelayW-1:0]  period;
    logic               ready;
  } entry_t;

endpackage

`default_nettype wire

>>> sv/periodic_task_timer_table.sv
// Timer table for a cooperative task scheduler.
// Input channel (in_valid_i/in_ready_o) carries one command per transfer:
// tick, set task, delete task or dispatch ready tasks. Output channel
// (out_valid_o/out_ready_i) returns one result per transfer; last_o marks
// the final result of a command, and entries_used_o is the table occupancy
// after the whole command.
// The table lives in one synchronous memory with a registered read. A
// command walks the active entries through that single read port, one
// entry per cycle unless a tail move is under way, writing back modified
// entries on the write port behind the read. A dispatch pauses the walk
// for every one-shot entry it removes (tail read, then tail move). Ready
// ids of a dispatch are collected in a small buffer and offered after the
// walk, so that every result can report the final occupancy. A new command
// is accepted only once the last result of the previous one has been
// transferred.
// Reset empties the table at once; no clearing pass is needed since only
// entries below the occupancy count are ever read. When the receiver stalls,
// the current result is held and the block simply waits.
`default_nettype none

module periodic_task_timer_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [pttt_pkg::OpW-1:0]         opcode_i,
  input  wire logic [pttt_pkg::TaskIdW-1:0]     task_id_i,
  input  wire logic [pttt_pkg::DelayW-1:0]      start_delay_i,
  input  wire logic [pttt_pkg::DelayW-1:0]      repeat_period_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [pttt_pkg::StatusW-1:0]          status_o,
  output logic [pttt_pkg::TaskIdW-1:0]          ready_id_o,
  output logic                                  last_o,
  output logic [pttt_pkg::UsedW-1:0]            entries_used_o
);

  import pttt_pkg::*;

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmTailRd,
    FsmTailWr,
    FsmFin,
    FsmEmit
  } state_e;

  // Sequencer registers.
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [TaskIdW-1:0]  tid_q, tid_d;
  logic [DelayW-1:0]   dly_q, dly_d;
  logic [DelayW-1:0]   per_q, per_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rd_idx_q, rd_idx_d;
  logic                ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]     ev_idx_q, ev_idx_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic [ResCntW-1:0]  nres_q, nres_d;
  logic                found_q, found_d;
  logic                stop_q, stop_d;
  logic [ResIdxW-1:0]  emit_idx_q, emit_idx_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [TaskIdW-1:0]  out_id_q, out_id_d;
  logic                out_last_q, out_last_d;

  // Table memory ports.
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  entry_t              mem_wdata;
  entry_t              rdata_q;
  entry_t              mem_q [TABLE_DEPTH];

  // Dispatch result buffer.
  logic                res_we;
  logic [TaskIdW-1:0]  res_buf_q [MaxResults];

  logic [CntW-1:0]     cnt_m1;
  logic [IdxW-1:0]     tail_idx;
  logic                res_full;
  logic                halt;

  assign cnt_m1   = cnt_q - 1'b1;
  assign tail_idx = cnt_m1[IdxW-1:0];
  // True when the result about to be recorded is the last one a pass allows.
  assign res_full = (nres_q == ResCntW'(MaxResults - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_buf_q[nres_q[ResIdxW-1:0]] <= rdata_q.id;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tid_d        = tid_q;
    dly_d        = dly_q;
    per_d        = per_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    ev_vld_d     = 1'b0;
    ev_idx_d     = ev_idx_q;
    slot_d       = slot_q;
    nres_d       = nres_q;
    found_d      = found_q;
    stop_d       = stop_q;
    emit_idx_d   = emit_idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_idx_q[IdxW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = ev_idx_q;
    mem_wdata    = rdata_q;
    res_we       = 1'b0;
    halt         = 1'b0;

    case (state_q)
      FsmIdle: begin
        if (in_valid_i) begin
          op_d     = op_e'(opcode_i);
          tid_d    = task_id_i;
          dly_d    = start_delay_i;
          per_d    = repeat_period_i;
          rd_idx_d = '0;
          nres_d   = '0;
          found_d  = 1'b0;
          stop_d   = 1'b0;
          state_d  = FsmScan;
        end
      end

      FsmScan: begin
        // Evaluate the entry read in the previous cycle.
        if (ev_vld_q) begin
          case (op_q)
            OpTick: begin
              mem_we = 1'b1;
              if (rdata_q.delay == '0) begin
                mem_wdata.ready = 1'b1;
                mem_wdata.delay = rdata_q.period;
              end else begin
                mem_wdata.delay = rdata_q.delay - 1'b1;
              end
            end
            OpSet: begin
              if (rdata_q.id == tid_q) begin
                mem_we    = 1'b1;
                mem_wdata = '{id: tid_q, delay: dly_q, period: per_q, ready: 1'b0};
                found_d   = 1'b1;
                halt      = 1'b1;
                state_d   = FsmFin;
              end
            end
            OpDelete: begin
              if (rdata_q.id == tid_q) begin
                slot_d  = ev_idx_q;
                halt    = 1'b1;
                state_d = FsmTailRd;
              end
            end
            OpDispatch: begin
              if (rdata_q.ready) begin
                res_we = 1'b1;
                nres_d = nres_q + 1'b1;
                if (rdata_q.period == '0) begin
                  // One-shot entry: pull the tail entry into its slot.
                  slot_d  = ev_idx_q;
                  stop_d  = res_full;
                  halt    = 1'b1;
                  state_d = FsmTailRd;
                end else begin
                  mem_we          = 1'b1;
                  mem_wdata.ready = 1'b0;
                  if (res_full) begin
                    halt    = 1'b1;
                    state_d = FsmFin;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        // Issue the next read unless the walk has ended.
        if (!halt) begin
          if (rd_idx_q < cnt_q) begin
            mem_re   = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = rd_idx_q[IdxW-1:0];
            rd_idx_d = rd_idx_q + 1'b1;
          end else if (!ev_vld_q) begin
            state_d = FsmFin;
          end
        end
      end

      FsmTailRd: begin
        mem_re    = 1'b1;
        mem_raddr = tail_idx;
        state_d   = FsmTailWr;
      end

      FsmTailWr: begin
        if (slot_q != tail_idx) begin
          mem_we    = 1'b1;
          mem_waddr = slot_q;
          mem_wdata = rdata_q;
        end
        cnt_d = cnt_m1;
        // The moved entry is skipped: the walk resumes one slot further on.
        if (op_q == OpDispatch && !stop_q) begin
          rd_idx_d = CntW'(slot_q) + CntW'(1);
          state_d  = FsmScan;
        end else begin
          state_d = FsmFin;
        end
      end

      FsmFin: begin
        state_d     = FsmEmit;
        out_valid_d = 1'b1;
        out_id_d    = '0;
        out_last_d  = 1'b1;
        emit_idx_d  = ResIdxW'(1);
        case (op_q)
          OpTick: begin
            out_status_d = StatTick;
          end
          OpSet: begin
            if (tid_q == '0) begin
              out_status_d = StatIgnored;
            end else if (found_q) begin
              out_status_d = StatUpdated;
            end else if (cnt_q < DepthCnt) begin
              mem_we       = 1'b1;
              mem_waddr    = cnt_q[IdxW-1:0];
              mem_wdata    = '{id: tid_q, delay: dly_q, period: per_q, ready: 1'b0};
              cnt_d        = cnt_q + 1'b1;
              out_status_d = StatAdded;
            end else begin
              out_status_d = StatIgnored;
            end
          end
          OpDelete: begin
            out_status_d = StatDeleted;
          end
          OpDispatch: begin
            if (nres_q == '0) begin
              out_status_d = StatNone;
            end else begin
              out_status_d = StatReady;
              out_id_d     = res_buf_q[0];
              out_last_d   = (nres_q == ResCntW'(1));
            end
          end
          default: ;
        endcase
      end

      FsmEmit: begin
        if (out_ready_i) begin
          if (out_last_q) begin
            out_valid_d = 1'b0;
            state_d     = FsmIdle;
          end else begin
            out_id_d   = res_buf_q[emit_idx_q];
            out_last_d = ((ResCntW'(emit_idx_q) + ResCntW'(1)) == nres_q);
            emit_idx_d = emit_idx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FsmIdle;
      op_q         <= OpTick;
      tid_q        <= '0;
      dly_q        <= '0;
      per_q        <= '0;
      cnt_q        <= '0;
      rd_idx_q     <= '0;
      ev_vld_q     <= 1'b0;
      ev_idx_q     <= '0;
      slot_q       <= '0;
      nres_q       <= '0;
      found_q      <= 1'b0;
      stop_q       <= 1'b0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StatTick;
      out_id_q     <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      tid_q        <= tid_d;
      dly_q        <= dly_d;
      per_q        <= per_d;
      cnt_q        <= cnt_d;
      rd_idx_q     <= rd_idx_d;
      ev_vld_q     <= ev_vld_d;
      ev_idx_q     <= ev_idx_d;
      slot_q       <= slot_d;
      nres_q       <= nres_d;
      found_q      <= found_d;
      stop_q       <= stop_d;
      emit_idx_q   <= emit_idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_ready_o     = (state_q == FsmIdle);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign ready_id_o     = out_id_q;
  assign last_o         = out_last_q;
  assign entries_used_o = UsedW'(cnt_q);

  // The walk never reads an entry in the cycle it is rewritten.
  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("table read and write hit the same entry");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("entry count beyond table depth");

  a_nres_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= ResCntW'(MaxResults))
    else $error("dispatch result count beyond limit");

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!out_valid_o && state_q == FsmScan))
    else $error("accepted command did not start a table walk");

  a_count_stable_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FsmEmit) |=> $stable(cnt_q))
    else $error("occupancy changed while results were offered");

endmodule

`default_nettype wire
